// ===== hw/rtl/sctb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Split-class trace buffer package
// Shared constants, payload types, mode and class codes, and state encoding.
// ----------------------------------------------------------------------------
package sctb_pkg;

    localparam int DEPTH = 1024;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = AW + 1;

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_ALL = 3'd1,
        MODE_CPU = 3'd2,
        MODE_PPU = 3'd3,
        MODE_CLR = 3'd4
    } t_mode;

    localparam logic [2:0] SRC_CPU    = 3'd0;
    localparam logic [2:0] SRC_PPU    = 3'd1;
    localparam logic [2:0] SRC_APU    = 3'd2;
    localparam logic [2:0] SRC_MAPPER = 3'd3;

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_CPU  = 2'd1,
        CLS_PPU  = 2'd2
    } t_class;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_LINK,
        S_REC
    } t_state;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] cycle;
        logic [7:0]  event_type;
        logic [2:0]  source;
        logic [7:0]  target;
        logic [15:0] address;
        logic [7:0]  data_byte;
        logic [9:0]  age;
    } t_cmd;

    typedef struct packed {
        logic [9:0]  slot;
        logic        hit;
        logic [31:0] out_cycle;
        logic [7:0]  out_type;
        logic [2:0]  out_source;
        logic [7:0]  out_target;
        logic [15:0] out_address;
        logic [7:0]  out_data;
        logic [10:0] total_count;
        logic [10:0] cpu_count;
        logic [10:0] ppu_count;
    } t_rsp;

    // One stored trace record, as kept in the record memory.
    typedef struct packed {
        logic [31:0] rec_cycle;
        logic [7:0]  rec_type;
        logic [2:0]  rec_source;
        logic [7:0]  rec_target;
        logic [15:0] rec_address;
        logic [7:0]  rec_data;
    } t_record;

    localparam int REC_W = $bits(t_record);

    function automatic t_class class_of(input logic [2:0] src);
        t_class cls;
        cls = CLS_NONE;
        if (src == SRC_PPU) begin
            cls = CLS_PPU;
        end else if (src == SRC_CPU || src == SRC_APU || src == SRC_MAPPER) begin
            cls = CLS_CPU;
        end
        return cls;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/split_class_trace_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Split-class trace buffer
// Main ring of trace records plus CPU-side and PPU link rings, occupancy counts
// per class (one short after a class fills the ring) and n-th most recent lookup.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result beat
// appears on o_rsp with o_strobe high for one cycle and must be taken then.
// An add first reads the record memory at the cursor to learn the class of
// the record about to be overwritten, then writes it. A hit in read-all mode
// reads the record memory; a hit in a class ring reads the link memory and
// then the record memory, each with registered read data. Misses, clear and
// unused modes answer straight from the idle state. The result beat is
// registered and appears in the cycle after the item's last state, and busy
// is low again in that cycle. The memories have no reset and need no clearing
// pass; a depth write clamps the value into 1..1024 and empties the buffer.
// ----------------------------------------------------------------------------
module split_class_trace_buffer
    import sctb_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output      logic          busy,
    input  wire t_cmd          i_cmd,
    input  wire logic          i_cfg_we,
    input  wire logic [CW-1:0] i_cfg_wdata,
    output      logic          o_strobe,
    output      t_rsp          o_rsp
);

    t_state        r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [CW-1:0] r_depth, n_depth;
    logic [AW-1:0] r_main_cur, n_main_cur;
    logic [AW-1:0] r_cpu_cur, n_cpu_cur;
    logic [AW-1:0] r_ppu_cur, n_ppu_cur;
    logic [CW-1:0] r_held_total, n_held_total;
    logic [CW-1:0] r_held_cpu, n_held_cpu;
    logic [CW-1:0] r_held_ppu, n_held_ppu;
    logic [AW-1:0] r_slot, n_slot;
    logic          r_strobe, n_strobe;
    t_rsp          r_rsp, n_rsp;

    logic             rec_we;
    logic [AW-1:0]    rec_raddr;
    logic [REC_W-1:0] rec_wdata_raw;
    logic [REC_W-1:0] rec_rdata_raw;
    t_record          rec_wdata;
    t_record          rec_rdata;
    logic             cpu_link_we;
    logic             ppu_link_we;
    logic [AW-1:0]    link_raddr;
    logic [AW-1:0]    cpu_link_rdata;
    logic [AW-1:0]    ppu_link_rdata;
    logic [AW-1:0]    link_sel;

    logic [AW-1:0]    sel_cur;
    logic [CW-1:0]    sel_cnt;
    logic [CW-1:0]    age_ext;
    logic             sel_hit;
    logic [AW-1:0]    back_idx;
    logic [CW:0]      back_sum;

    // ------------------------------------------------------------------------
    // Lookup position: the ring chosen by the incoming mode, age steps back.
    // ------------------------------------------------------------------------
    always_comb begin
        unique case (i_cmd.mode)
            MODE_CPU: begin
                sel_cur = r_cpu_cur;
                sel_cnt = r_held_cpu;
            end
            MODE_PPU: begin
                sel_cur = r_ppu_cur;
                sel_cnt = r_held_ppu;
            end
            default: begin
                sel_cur = r_main_cur;
                sel_cnt = r_held_total;
            end
        endcase
    end

    assign age_ext  = {1'b0, i_cmd.age};
    assign sel_hit  = (age_ext < sel_cnt) && (age_ext < r_depth);
    assign back_sum = {2'b00, sel_cur} + {1'b0, r_depth} - (CW + 1)'(1) - {1'b0, age_ext};
    assign back_idx = (back_sum >= {1'b0, r_depth}) ?
                      AW'(back_sum - {1'b0, r_depth}) : AW'(back_sum);

    assign link_sel = (r_cmd.mode == MODE_CPU) ? cpu_link_rdata : ppu_link_rdata;
    assign rec_rdata = t_record'(rec_rdata_raw);
    assign rec_wdata_raw = REC_W'(rec_wdata);

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_cmd.mode)
                        MODE_ADD: n_state = S_ADD;
                        MODE_ALL: n_state = sel_hit ? S_REC : S_IDLE;
                        MODE_CPU,
                        MODE_PPU: n_state = sel_hit ? S_LINK : S_IDLE;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD:   n_state = S_IDLE;
            S_LINK:  n_state = S_REC;
            S_REC:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Datapath, memory controls and result beat
    // ------------------------------------------------------------------------
    always_comb begin
        t_class        new_cls;
        t_class        old_cls;
        logic          full;
        logic [CW-1:0] cpu_tmp;
        logic [CW-1:0] ppu_tmp;

        new_cls = class_of(r_cmd.source);
        old_cls = class_of(rec_rdata.rec_source);
        full    = (r_held_total >= r_depth);
        cpu_tmp = r_held_cpu;
        ppu_tmp = r_held_ppu;

        n_cmd        = r_cmd;
        n_depth      = r_depth;
        n_main_cur   = r_main_cur;
        n_cpu_cur    = r_cpu_cur;
        n_ppu_cur    = r_ppu_cur;
        n_held_total = r_held_total;
        n_held_cpu   = r_held_cpu;
        n_held_ppu   = r_held_ppu;
        n_slot       = r_slot;
        n_strobe     = 1'b0;
        n_rsp        = '0;

        rec_we      = 1'b0;
        rec_raddr   = r_main_cur;
        cpu_link_we = 1'b0;
        ppu_link_we = 1'b0;
        link_raddr  = back_idx;

        rec_wdata.rec_cycle   = r_cmd.cycle;
        rec_wdata.rec_type    = r_cmd.event_type;
        rec_wdata.rec_source  = r_cmd.source;
        rec_wdata.rec_target  = r_cmd.target;
        rec_wdata.rec_address = r_cmd.address;
        rec_wdata.rec_data    = r_cmd.data_byte;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd = i_cmd;
                    unique case (i_cmd.mode)
                        MODE_ADD: begin
                            // Fetch the record about to be overwritten.
                            rec_raddr = r_main_cur;
                        end
                        MODE_ALL,
                        MODE_CPU,
                        MODE_PPU: begin
                            rec_raddr = back_idx;
                            n_slot    = back_idx;
                            if (!sel_hit) begin
                                n_strobe          = 1'b1;
                                n_rsp.total_count = r_held_total;
                                n_rsp.cpu_count   = r_held_cpu;
                                n_rsp.ppu_count   = r_held_ppu;
                            end
                        end
                        MODE_CLR: begin
                            n_main_cur   = '0;
                            n_cpu_cur    = '0;
                            n_ppu_cur    = '0;
                            n_held_total = '0;
                            n_held_cpu   = '0;
                            n_held_ppu   = '0;
                            n_strobe     = 1'b1;
                        end
                        default: begin
                            n_strobe          = 1'b1;
                            n_rsp.total_count = r_held_total;
                            n_rsp.cpu_count   = r_held_cpu;
                            n_rsp.ppu_count   = r_held_ppu;
                        end
                    endcase
                end
            end
            S_ADD: begin
                rec_we     = 1'b1;
                n_main_cur = ({1'b0, r_main_cur} + CW'(1) == r_depth) ?
                             '0 : r_main_cur + AW'(1);
                if (new_cls == CLS_CPU) begin
                    cpu_link_we = 1'b1;
                    n_cpu_cur   = ({1'b0, r_cpu_cur} + CW'(1) == r_depth) ?
                                  '0 : r_cpu_cur + AW'(1);
                    if (r_held_cpu < r_depth) begin
                        cpu_tmp = r_held_cpu + CW'(1);
                    end
                end else if (new_cls == CLS_PPU) begin
                    ppu_link_we = 1'b1;
                    n_ppu_cur   = ({1'b0, r_ppu_cur} + CW'(1) == r_depth) ?
                                  '0 : r_ppu_cur + AW'(1);
                    if (r_held_ppu < r_depth) begin
                        ppu_tmp = r_held_ppu + CW'(1);
                    end
                end
                // A full ring loses its oldest record from that record's class.
                if (!full) begin
                    n_held_total = r_held_total + CW'(1);
                end else if (old_cls == CLS_CPU) begin
                    if (cpu_tmp != '0) begin
                        cpu_tmp = cpu_tmp - CW'(1);
                    end
                end else if (old_cls == CLS_PPU) begin
                    if (ppu_tmp != '0) begin
                        ppu_tmp = ppu_tmp - CW'(1);
                    end
                end
                n_held_cpu        = cpu_tmp;
                n_held_ppu        = ppu_tmp;
                n_strobe          = 1'b1;
                n_rsp.slot        = r_main_cur;
                n_rsp.total_count = n_held_total;
                n_rsp.cpu_count   = cpu_tmp;
                n_rsp.ppu_count   = ppu_tmp;
            end
            S_LINK: begin
                rec_raddr = link_sel;
                n_slot    = link_sel;
            end
            S_REC: begin
                n_strobe          = 1'b1;
                n_rsp.slot        = r_slot;
                n_rsp.hit         = 1'b1;
                n_rsp.out_cycle   = rec_rdata.rec_cycle;
                n_rsp.out_type    = rec_rdata.rec_type;
                n_rsp.out_source  = rec_rdata.rec_source;
                n_rsp.out_target  = rec_rdata.rec_target;
                n_rsp.out_address = rec_rdata.rec_address;
                n_rsp.out_data    = rec_rdata.rec_data;
                n_rsp.total_count = r_held_total;
                n_rsp.cpu_count   = r_held_cpu;
                n_rsp.ppu_count   = r_held_ppu;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase

        // A new depth invalidates every stored position.
        if (i_cfg_we) begin
            if (i_cfg_wdata == '0) begin
                n_depth = CW'(1);
            end else if (i_cfg_wdata > CW'(DEPTH)) begin
                n_depth = CW'(DEPTH);
            end else begin
                n_depth = i_cfg_wdata;
            end
            n_main_cur   = '0;
            n_cpu_cur    = '0;
            n_ppu_cur    = '0;
            n_held_total = '0;
            n_held_cpu   = '0;
            n_held_ppu   = '0;
        end
    end

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_depth      <= CW'(DEPTH);
            r_main_cur   <= '0;
            r_cpu_cur    <= '0;
            r_ppu_cur    <= '0;
            r_held_total <= '0;
            r_held_cpu   <= '0;
            r_held_ppu   <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_depth      <= n_depth;
            r_main_cur   <= n_main_cur;
            r_cpu_cur    <= n_cpu_cur;
            r_ppu_cur    <= n_ppu_cur;
            r_held_total <= n_held_total;
            r_held_cpu   <= n_held_cpu;
            r_held_ppu   <= n_held_ppu;
            r_strobe     <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_slot <= n_slot;
        r_rsp  <= n_rsp;
    end

    // ------------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------------
    sctb_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (r_main_cur),
        .i_wdata (rec_wdata_raw),
        .i_raddr (rec_raddr),
        .o_rdata (rec_rdata_raw)
    );

    sctb_ram #(
        .WIDTH (AW),
        .DEPTH (DEPTH)
    ) u_cpu_link_ram (
        .i_clk   (i_clk),
        .i_we    (cpu_link_we),
        .i_waddr (r_cpu_cur),
        .i_wdata (r_main_cur),
        .i_raddr (link_raddr),
        .o_rdata (cpu_link_rdata)
    );

    sctb_ram #(
        .WIDTH (AW),
        .DEPTH (DEPTH)
    ) u_ppu_link_ram (
        .i_clk   (i_clk),
        .i_we    (ppu_link_we),
        .i_waddr (r_ppu_cur),
        .i_wdata (r_main_cur),
        .i_raddr (link_raddr),
        .o_rdata (ppu_link_rdata)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_total_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_total <= r_depth)
        else $error("total count exceeds the ring depth");

    a_class_sum : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_held_cpu} + {1'b0, r_held_ppu}) <= {1'b0, r_held_total})
        else $error("class counts exceed the total count");

    a_cursor_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_main_cur} < r_depth) && ({1'b0, r_cpu_cur} < r_depth) &&
        ({1'b0, r_ppu_cur} < r_depth))
        else $error("ring cursor beyond the depth in use");

    a_rec_hit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REC) |=> (o_strobe && o_rsp.hit))
        else $error("record fetch did not end in a hit beat");

    a_add_beat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD && !i_cfg_we) |=> (o_strobe && !o_rsp.hit && !busy))
        else $error("add did not end in a single result beat");

endmodule
`default_nettype wire

// ===== hw/rtl/sctb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sctb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire
